// File: hw/rtl/gwpp_pkg.sv
// ----------------------------------------------------------------------------
// gwpp_pkg: shared types and constants of the grid wavefront path planner
// Request and status codes, register indexes, neighbour steps, reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package gwpp_pkg;

	localparam int GRID_SIDE_DEF = 64;
	localparam int RING_MAX      = 6;

	typedef enum logic [1:0] {
		FN_LOAD = 2'd0,
		FN_PLAN = 2'd1,
		FN_READ = 2'd2,
		FN_NOP  = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_GOAL_BAD  = 2'd1,
		ST_NO_PATH   = 2'd2,
		ST_BAD_INDEX = 2'd3
	} status_t;

	localparam logic [2:0] REG_GRID_WIDTH  = 3'd0;
	localparam logic [2:0] REG_GRID_HEIGHT = 3'd1;
	localparam logic [2:0] REG_ALLOW_UNK   = 3'd2;
	localparam logic [2:0] REG_INFLATION   = 3'd3;
	localparam logic [2:0] REG_MIN_SEGMENT = 3'd4;

	localparam logic [6:0] GRID_WIDTH_RST  = 7'd64;
	localparam logic [6:0] GRID_HEIGHT_RST = 7'd64;
	localparam logic [2:0] INFLATION_RST   = 3'd2;
	localparam logic [6:0] MIN_SEGMENT_RST = 7'd5;

	// neighbour order: left, right, up, down
	localparam logic signed [3:0] STEP_DX [4] = '{-4'sd1, 4'sd1, 4'sd0, 4'sd0};
	localparam logic signed [3:0] STEP_DY [4] = '{4'sd0, 4'sd0, -4'sd1, 4'sd1};

endpackage

`default_nettype wire

// File: hw/rtl/grid_wavefront_path_planner.sv
// ----------------------------------------------------------------------------
// grid_wavefront_path_planner: BFS wavefront planner on an occupancy grid
// Loads cells, inflates obstacles, runs a four-neighbour wave from the goal,
// descends from the start and keeps direction-change waypoints.
// ----------------------------------------------------------------------------
//  channel   signals                                        transaction
//  in        in_valid / in_ready, func .. waypoint_index    one request
//  out       out_valid / out_ready, status .. start_moved   one result per request
//  cfg       cfg_en, cfg_addr, cfg_wdata                    one register write
//
//  Load and no-op go straight to the result. Read makes one waypoint memory
//  read, which is skipped when the index is out of range.
//  Plan: a clear sweep of every memory entry, a scan of the active cells that
//  marks blocked a (2r+1)^2 square around each occupied cell, then the wave,
//  which dequeues cells and probes their inside neighbours; each memory probe
//  has an issue and a check state. After reset a pass clears the occupancy memory; in_ready
//  stays low meanwhile. A request is taken only when the sequencer is idle; a
//  finished result waits in the output register while out_ready is low.
`default_nettype none

module grid_wavefront_path_planner
	import gwpp_pkg::*;
#(
	parameter int GRID_SIDE = GRID_SIDE_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_en,
	input  wire logic [2:0]  cfg_addr,
	input  wire logic [6:0]  cfg_wdata,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  func,
	input  wire logic [5:0]  cell_x,
	input  wire logic [5:0]  cell_y,
	input  wire logic        cell_occupied,
	input  wire logic        cell_unknown,
	input  wire logic [5:0]  start_x,
	input  wire logic [5:0]  start_y,
	input  wire logic [5:0]  goal_x,
	input  wire logic [5:0]  goal_y,
	input  wire logic [11:0] waypoint_index,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [1:0]       status,
	output logic [12:0]      waypoint_count,
	output logic [5:0]       waypoint_x,
	output logic [5:0]       waypoint_y,
	output logic             start_moved
);

	localparam int AW    = $clog2(GRID_SIDE);
	localparam int XW    = (AW > 6) ? AW : 6;
	localparam int SW    = XW + 2;
	localparam int IW    = 2 * AW;
	localparam int DW    = IW + 1;
	localparam int CW    = IW + 1;
	localparam int DEPTH = 1 << IW;

	typedef enum logic [4:0] {
		S_INIT, S_IDLE, S_FIN, S_RD, S_RD_D,
		P_CLR, P_SCAN_RD, P_SCAN_CHK, P_SCAN_NXT, P_INF,
		P_ST_RD, P_ST_CHK, P_RING, P_RING_CHK, P_RING_NXT,
		P_GOAL_SET, P_GOAL_RD, P_GOAL_CHK,
		P_POP_RD, P_POP_CHK, P_CUR_RD, P_CUR_CHK, P_NB_RD, P_NB_CHK,
		P_BFS_END, P_SR_RD, P_SR_CHK,
		P_D_TEST, P_DN_RD, P_DN_CHK, P_D_MOVE, P_D_FINAL
	} state_t;

	state_t state_q;

	logic [6:0] gw_q, gh_q, ms_q;
	logic       allow_q;
	logic [2:0] infl_q;

	logic [1:0]    occ_mem  [DEPTH];
	logic          blk_mem  [DEPTH];
	logic          rch_mem  [DEPTH];
	logic [DW-1:0] dist_mem [DEPTH];
	logic [IW-1:0] fq_mem   [DEPTH];
	logic [IW-1:0] wp_mem   [DEPTH];

	logic [1:0]    occ_rd_q;
	logic          blk_rd_q, rch_rd_q;
	logic [DW-1:0] dist_rd_q;
	logic [IW-1:0] fq_rd_q, wp_rd_q;

	logic signed [SW-1:0] bx_q, by_q, sx_q, sy_q, gx_q, gy_q;
	logic signed [3:0]    ox_q, oy_q;
	logic [2:0]           rr_q;
	logic [IW-1:0]        clr_q, wpk_q;
	logic [CW-1:0]        head_q, tail_q, cnt_q, stored_cnt_q;
	logic [DW-1:0]        curd_q, bd_q;
	logic [1:0]           nb_q, bdir_q, pdir_q;
	logic                 found_q, mv1_q, moved_q;
	logic [6:0]           seg_q;

	status_t    res_status_q;
	logic [5:0] res_x_q, res_y_q;

	logic        out_valid_q, out_moved_q;
	logic [1:0]  out_status_q;
	logic [12:0] out_count_q;
	logic [5:0]  out_x_q, out_y_q;

	logic signed [SW-1:0] act_w, act_h, px, py;
	logic signed [3:0]    off_x, off_y, inf_r, ring_r, ring_r1;
	logic                 inside_p, walk_p, start_in, seg_ok;
	logic [IW-1:0]        idx_p, idx_b, idx_s;
	logic [6:0]           ms_eff;

	logic                 occ_we, blk_we, rch_we, dist_we, fq_we, wp_we;
	logic [IW-1:0]        occ_wa, blk_wa, rch_wa, dist_wa, fq_wa, wp_wa;
	logic [1:0]           occ_wd;
	logic                 blk_wd, rch_wd;
	logic [DW-1:0]        dist_wd;
	logic [IW-1:0]        fq_wd, wp_wd;

	logic in_acc;

	assign in_ready       = (state_q == S_IDLE);
	assign in_acc         = in_valid && in_ready;
	assign out_valid      = out_valid_q;
	assign status         = out_status_q;
	assign waypoint_count = out_count_q;
	assign waypoint_x     = out_x_q;
	assign waypoint_y     = out_y_q;
	assign start_moved    = out_moved_q;

	always_comb begin
		if (gw_q == '0) begin
			act_w = SW'(1);
		end else if (32'(gw_q) > GRID_SIDE) begin
			act_w = SW'(GRID_SIDE);
		end else begin
			act_w = SW'(gw_q);
		end
		if (gh_q == '0) begin
			act_h = SW'(1);
		end else if (32'(gh_q) > GRID_SIDE) begin
			act_h = SW'(GRID_SIDE);
		end else begin
			act_h = SW'(gh_q);
		end
	end

	always_comb begin
		case (state_q)
			P_NB_RD, P_NB_CHK, P_DN_RD, P_DN_CHK: begin
				off_x = STEP_DX[nb_q];
				off_y = STEP_DY[nb_q];
			end
			default: begin
				off_x = ox_q;
				off_y = oy_q;
			end
		endcase
	end

	// shared probe unit: base cell plus offset, bounds and walkability
	assign px       = bx_q + SW'(off_x);
	assign py       = by_q + SW'(off_y);
	assign inside_p = !px[SW-1] && !py[SW-1] && (px < act_w) && (py < act_h);
	assign idx_p    = {py[AW-1:0], px[AW-1:0]};
	assign idx_b    = {by_q[AW-1:0], bx_q[AW-1:0]};
	assign idx_s    = {sy_q[AW-1:0], sx_q[AW-1:0]};
	assign walk_p   = inside_p && !blk_rd_q && !(occ_rd_q[1] && !allow_q);
	assign start_in = !sx_q[SW-1] && !sy_q[SW-1] && (sx_q < act_w) && (sy_q < act_h);
	assign inf_r    = $signed({1'b0, infl_q});
	assign ring_r   = $signed({1'b0, rr_q});
	assign ring_r1  = $signed({1'b0, rr_q + 3'd1});
	assign ms_eff   = (ms_q == '0) ? 7'd1 : ms_q;
	assign seg_ok   = (seg_q >= ms_eff);

	always_comb begin
		occ_we  = 1'b0;
		occ_wa  = clr_q;
		occ_wd  = 2'b00;
		blk_we  = 1'b0;
		blk_wa  = clr_q;
		blk_wd  = 1'b0;
		rch_we  = 1'b0;
		rch_wa  = clr_q;
		rch_wd  = 1'b0;
		dist_we = 1'b0;
		dist_wa = idx_p;
		dist_wd = '0;
		fq_we   = 1'b0;
		fq_wa   = tail_q[IW-1:0];
		fq_wd   = idx_p;
		wp_we   = 1'b0;
		wp_wa   = cnt_q[IW-1:0];
		wp_wd   = idx_b;
		unique case (state_q)
			S_INIT: begin
				occ_we = 1'b1;
			end
			S_IDLE: begin
				if (in_acc && func == FN_LOAD && 32'(cell_x) < GRID_SIDE
						&& 32'(cell_y) < GRID_SIDE) begin
					occ_we = 1'b1;
					occ_wa = {cell_y[AW-1:0], cell_x[AW-1:0]};
					occ_wd = {cell_unknown, cell_occupied};
				end
			end
			P_CLR: begin
				blk_we = 1'b1;
				rch_we = 1'b1;
			end
			P_INF: begin
				blk_we = inside_p;
				blk_wa = idx_p;
				blk_wd = 1'b1;
			end
			P_GOAL_CHK: begin
				if (inside_p && !blk_rd_q) begin
					rch_we  = 1'b1;
					rch_wa  = idx_p;
					rch_wd  = 1'b1;
					dist_we = 1'b1;
					fq_we   = 1'b1;
					fq_wa   = '0;
				end
			end
			P_NB_CHK: begin
				if (walk_p && !rch_rd_q) begin
					rch_we  = 1'b1;
					rch_wa  = idx_p;
					rch_wd  = 1'b1;
					dist_we = 1'b1;
					dist_wd = DW'(curd_q + DW'(1));
					fq_we   = (tail_q < CW'(DEPTH));
				end
			end
			P_SR_CHK: begin
				wp_we = inside_p && rch_rd_q;
				wp_wa = '0;
			end
			P_D_MOVE: begin
				wp_we = found_q && mv1_q && (bdir_q != pdir_q) && seg_ok;
			end
			P_D_FINAL: begin
				wp_we = mv1_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (occ_we) begin
			occ_mem[occ_wa] <= occ_wd;
		end
		occ_rd_q <= occ_mem[idx_p];
	end

	always_ff @(posedge clk) begin
		if (blk_we) begin
			blk_mem[blk_wa] <= blk_wd;
		end
		blk_rd_q <= blk_mem[idx_p];
	end

	always_ff @(posedge clk) begin
		if (rch_we) begin
			rch_mem[rch_wa] <= rch_wd;
		end
		rch_rd_q <= rch_mem[idx_p];
	end

	always_ff @(posedge clk) begin
		if (dist_we) begin
			dist_mem[dist_wa] <= dist_wd;
		end
		dist_rd_q <= dist_mem[idx_p];
	end

	always_ff @(posedge clk) begin
		if (fq_we) begin
			fq_mem[fq_wa] <= fq_wd;
		end
		fq_rd_q <= fq_mem[head_q[IW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (wp_we) begin
			wp_mem[wp_wa] <= wp_wd;
		end
		wp_rd_q <= wp_mem[wpk_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_INIT;
			gw_q         <= GRID_WIDTH_RST;
			gh_q         <= GRID_HEIGHT_RST;
			allow_q      <= 1'b0;
			infl_q       <= INFLATION_RST;
			ms_q         <= MIN_SEGMENT_RST;
			clr_q        <= '0;
			head_q       <= '0;
			tail_q       <= '0;
			cnt_q        <= '0;
			stored_cnt_q <= '0;
			out_valid_q  <= 1'b0;
			nb_q         <= '0;
			found_q      <= 1'b0;
			mv1_q        <= 1'b0;
			moved_q      <= 1'b0;
			rr_q         <= '0;
		end else begin
			if (cfg_en) begin
				case (cfg_addr)
					REG_GRID_WIDTH:  gw_q    <= cfg_wdata;
					REG_GRID_HEIGHT: gh_q    <= cfg_wdata;
					REG_ALLOW_UNK:   allow_q <= cfg_wdata[0];
					REG_INFLATION:   infl_q  <= cfg_wdata[2:0];
					REG_MIN_SEGMENT: ms_q    <= cfg_wdata;
					default: begin
					end
				endcase
			end
			if (out_valid_q && out_ready && state_q != S_FIN) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_INIT: begin
					clr_q <= clr_q + IW'(1);
					if (&clr_q) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_acc) begin
						res_status_q <= ST_OK;
						res_x_q      <= '0;
						res_y_q      <= '0;
						moved_q      <= 1'b0;
						unique case (func_t'(func))
							FN_PLAN: begin
								sx_q    <= SW'(start_x);
								sy_q    <= SW'(start_y);
								gx_q    <= SW'(goal_x);
								gy_q    <= SW'(goal_y);
								clr_q   <= '0;
								state_q <= P_CLR;
							end
							FN_READ: begin
								if (32'(waypoint_index) >= 32'(stored_cnt_q)) begin
									res_status_q <= ST_BAD_INDEX;
									state_q      <= S_FIN;
								end else begin
									wpk_q   <= IW'(waypoint_index);
									state_q <= S_RD;
								end
							end
							FN_LOAD, FN_NOP: begin
								state_q <= S_FIN;
							end
						endcase
					end
				end
				S_RD: begin
					state_q <= S_RD_D;
				end
				S_RD_D: begin
					res_x_q <= 6'(wp_rd_q[AW-1:0]);
					res_y_q <= 6'(wp_rd_q[IW-1:AW]);
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q  <= 1'b1;
						out_status_q <= res_status_q;
						out_count_q  <= 13'(stored_cnt_q);
						out_x_q      <= res_x_q;
						out_y_q      <= res_y_q;
						out_moved_q  <= moved_q;
						state_q      <= S_IDLE;
					end
				end
				P_CLR: begin
					clr_q <= clr_q + IW'(1);
					if (&clr_q) begin
						bx_q    <= '0;
						by_q    <= '0;
						ox_q    <= '0;
						oy_q    <= '0;
						state_q <= P_SCAN_RD;
					end
				end
				P_SCAN_RD: begin
					state_q <= P_SCAN_CHK;
				end
				P_SCAN_CHK: begin
					if (occ_rd_q[0]) begin
						ox_q    <= -inf_r;
						oy_q    <= -inf_r;
						state_q <= P_INF;
					end else begin
						state_q <= P_SCAN_NXT;
					end
				end
				P_INF: begin
					if (ox_q < inf_r) begin
						ox_q <= ox_q + 4'sd1;
					end else begin
						ox_q <= -inf_r;
						if (oy_q < inf_r) begin
							oy_q <= oy_q + 4'sd1;
						end else begin
							ox_q    <= '0;
							oy_q    <= '0;
							state_q <= P_SCAN_NXT;
						end
					end
				end
				P_SCAN_NXT: begin
					if (bx_q + SW'(1) < act_w) begin
						bx_q    <= bx_q + SW'(1);
						state_q <= P_SCAN_RD;
					end else if (by_q + SW'(1) < act_h) begin
						bx_q    <= '0;
						by_q    <= by_q + SW'(1);
						state_q <= P_SCAN_RD;
					end else begin
						bx_q    <= sx_q;
						by_q    <= sy_q;
						state_q <= P_ST_RD;
					end
				end
				P_ST_RD: begin
					state_q <= P_ST_CHK;
				end
				P_ST_CHK: begin
					if (walk_p) begin
						state_q <= P_GOAL_SET;
					end else begin
						rr_q    <= 3'd1;
						ox_q    <= -4'sd1;
						oy_q    <= -4'sd1;
						state_q <= P_RING;
					end
				end
				P_RING: begin
					if ((ox_q == ring_r || ox_q == -ring_r || oy_q == ring_r
							|| oy_q == -ring_r) && inside_p) begin
						state_q <= P_RING_CHK;
					end else begin
						state_q <= P_RING_NXT;
					end
				end
				P_RING_CHK: begin
					if (walk_p) begin
						sx_q    <= px;
						sy_q    <= py;
						moved_q <= 1'b1;
						state_q <= P_GOAL_SET;
					end else begin
						state_q <= P_RING_NXT;
					end
				end
				P_RING_NXT: begin
					state_q <= P_RING;
					if (oy_q < ring_r) begin
						oy_q <= oy_q + 4'sd1;
					end else begin
						oy_q <= -ring_r;
						if (ox_q < ring_r) begin
							ox_q <= ox_q + 4'sd1;
						end else if (32'(rr_q) < RING_MAX) begin
							rr_q <= rr_q + 3'd1;
							ox_q <= -ring_r1;
							oy_q <= -ring_r1;
						end else begin
							state_q <= P_GOAL_SET;
						end
					end
				end
				P_GOAL_SET: begin
					bx_q    <= gx_q;
					by_q    <= gy_q;
					ox_q    <= '0;
					oy_q    <= '0;
					state_q <= P_GOAL_RD;
				end
				P_GOAL_RD: begin
					state_q <= P_GOAL_CHK;
				end
				P_GOAL_CHK: begin
					if (!inside_p || blk_rd_q) begin
						res_status_q <= ST_GOAL_BAD;
						state_q      <= S_FIN;
					end else begin
						head_q  <= '0;
						tail_q  <= CW'(1);
						state_q <= P_POP_RD;
					end
				end
				P_POP_RD: begin
					state_q <= (head_q < tail_q) ? P_POP_CHK : P_BFS_END;
				end
				P_POP_CHK: begin
					head_q <= head_q + CW'(1);
					bx_q   <= SW'(fq_rd_q[AW-1:0]);
					by_q   <= SW'(fq_rd_q[IW-1:AW]);
					if (start_in && fq_rd_q == idx_s) begin
						state_q <= P_BFS_END;
					end else begin
						state_q <= P_CUR_RD;
					end
				end
				P_CUR_RD: begin
					state_q <= P_CUR_CHK;
				end
				P_CUR_CHK: begin
					curd_q  <= dist_rd_q;
					nb_q    <= '0;
					state_q <= P_NB_RD;
				end
				P_NB_RD: begin
					if (inside_p) begin
						state_q <= P_NB_CHK;
					end else if (nb_q == 2'd3) begin
						state_q <= P_POP_RD;
					end else begin
						nb_q <= nb_q + 2'd1;
					end
				end
				P_NB_CHK: begin
					if (walk_p && !rch_rd_q && tail_q < CW'(DEPTH)) begin
						tail_q <= tail_q + CW'(1);
					end
					nb_q    <= nb_q + 2'd1;
					state_q <= (nb_q == 2'd3) ? P_POP_RD : P_NB_RD;
				end
				P_BFS_END: begin
					bx_q    <= sx_q;
					by_q    <= sy_q;
					ox_q    <= '0;
					oy_q    <= '0;
					state_q <= P_SR_RD;
				end
				P_SR_RD: begin
					state_q <= P_SR_CHK;
				end
				P_SR_CHK: begin
					if (!inside_p || !rch_rd_q) begin
						res_status_q <= ST_NO_PATH;
						state_q      <= S_FIN;
					end else begin
						curd_q  <= dist_rd_q;
						cnt_q   <= CW'(1);
						mv1_q   <= 1'b0;
						state_q <= P_D_TEST;
					end
				end
				P_D_TEST: begin
					if (bx_q == gx_q && by_q == gy_q) begin
						state_q <= P_D_FINAL;
					end else begin
						nb_q    <= '0;
						found_q <= 1'b0;
						bd_q    <= curd_q;
						state_q <= P_DN_RD;
					end
				end
				P_DN_RD: begin
					if (inside_p) begin
						state_q <= P_DN_CHK;
					end else if (nb_q == 2'd3) begin
						state_q <= P_D_MOVE;
					end else begin
						nb_q <= nb_q + 2'd1;
					end
				end
				P_DN_CHK: begin
					if (rch_rd_q && dist_rd_q < bd_q) begin
						bd_q    <= dist_rd_q;
						bdir_q  <= nb_q;
						found_q <= 1'b1;
					end
					nb_q    <= nb_q + 2'd1;
					state_q <= (nb_q == 2'd3) ? P_D_MOVE : P_DN_RD;
				end
				P_D_MOVE: begin
					if (!found_q) begin
						state_q <= P_D_FINAL;
					end else begin
						if (!mv1_q) begin
							seg_q <= 7'd1;
						end else if (bdir_q != pdir_q && seg_ok) begin
							cnt_q <= cnt_q + CW'(1);
							seg_q <= 7'd1;
						end else if (seg_q != 7'h7f) begin
							seg_q <= seg_q + 7'd1;
						end
						pdir_q  <= bdir_q;
						mv1_q   <= 1'b1;
						bx_q    <= bx_q + SW'(STEP_DX[bdir_q]);
						by_q    <= by_q + SW'(STEP_DY[bdir_q]);
						curd_q  <= bd_q;
						state_q <= P_D_TEST;
					end
				end
				P_D_FINAL: begin
					stored_cnt_q <= mv1_q ? cnt_q + CW'(1) : cnt_q;
					state_q      <= S_FIN;
				end
			endcase
		end
	end

`ifndef SYNTH
	a_queue_order: assert property (@(posedge clk) disable iff (!arst_n)
		head_q <= tail_q)
		else $error("frontier head passed tail");

	a_bad_index_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == 2'(ST_BAD_INDEX)) |-> (waypoint_x == '0 && waypoint_y == '0))
		else $error("out of range read returned coordinates");

	a_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(stored_cnt_q != $past(stored_cnt_q)) |-> (stored_cnt_q != '0))
		else $error("successful plan stored no waypoint");
`endif

endmodule

`default_nettype wire

// File: bench/grid_wavefront_path_planner_test.sv
// ----------------------------------------------------------------------------
// grid_wavefront_path_planner_test: self-checking bench for the path planner
// Drives load, plan, read and no-op requests with random gaps and output
// stalls, predicts each result with an in-bench planner model and compares
// every result field by field in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module grid_wavefront_path_planner_test;
	import gwpp_pkg::*;

	localparam int SIDE       = 64;
	localparam int CELLS      = SIDE * SIDE;
	localparam int IDLE_LIMIT = 1000000;

	typedef struct {
		func_t       fn;
		bit [5:0]    cx, cy;
		bit          occ, unk;
		bit [5:0]    sx, sy, gx, gy;
		bit [11:0]   idx;
	} request_t;

	typedef struct {
		status_t     st;
		bit [12:0]   count;
		bit [5:0]    wx, wy;
		bit          moved;
	} result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_en = 1'b0;
	logic [2:0]  cfg_addr = '0;
	logic [6:0]  cfg_wdata = '0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  func = '0;
	logic [5:0]  cell_x = '0, cell_y = '0;
	logic        cell_occupied = 1'b0, cell_unknown = 1'b0;
	logic [5:0]  start_x = '0, start_y = '0, goal_x = '0, goal_y = '0;
	logic [11:0] waypoint_index = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [1:0]  status;
	logic [12:0] waypoint_count;
	logic [5:0]  waypoint_x, waypoint_y;
	logic        start_moved;

	grid_wavefront_path_planner dut (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// planner state mirror
	bit [1:0]  occ_cells [CELLS];
	bit        blocked_cells [CELLS];
	bit        wave_seen [CELLS];
	int        wave_dist [CELLS];
	int        wave_fifo [CELLS];
	int        trace [CELLS];
	int        waypoints [CELLS];
	int        waypoint_total;
	int        cfg_w = 64, cfg_h = 64, cfg_unk = 0, cfg_infl = 2, cfg_seg = 5;
	int        act_w, act_h;

	result_t   expected_results [$];
	int        mismatches;
	bit        calm;
	int        hold_off;
	bit        finished_sending;

	function automatic int clamp_dim(int v);
		if (v == 0) return 1;
		if (v > SIDE) return SIDE;
		return v;
	endfunction

	function automatic bit in_grid(int x, int y);
		return x >= 0 && y >= 0 && x < act_w && y < act_h;
	endfunction

	function automatic bit passable(int x, int y);
		if (!in_grid(x, y)) return 0;
		if (blocked_cells[y*SIDE+x]) return 0;
		if (occ_cells[y*SIDE+x][1] && cfg_unk == 0) return 0;
		return 1;
	endfunction

	function automatic status_t plan_path(int sx, int sy, int gx, int gy, output bit moved);
		int head, tail, cur, cx, cy, nx, ny, n, len, guard, bx, by, bd;
		int pdx, pdy, ddx, ddy, seg, cnt;
		bit found;
		moved = 0;
		for (int i = 0; i < CELLS; i++) blocked_cells[i] = 0;
		for (int y = 0; y < act_h; y++)
			for (int x = 0; x < act_w; x++) begin
				if (!occ_cells[y*SIDE+x][0]) continue;
				for (int dy = -cfg_infl; dy <= cfg_infl; dy++)
					for (int dx = -cfg_infl; dx <= cfg_infl; dx++)
						if (in_grid(x+dx, y+dy)) blocked_cells[(y+dy)*SIDE+x+dx] = 1;
			end
		if (!passable(sx, sy)) begin
			found = 0;
			for (int r = 1; r <= RING_MAX && !found; r++)
				for (int dx = -r; dx <= r && !found; dx++)
					for (int dy = -r; dy <= r && !found; dy++) begin
						if (dx != r && dx != -r && dy != r && dy != -r) continue;
						if (passable(sx+dx, sy+dy)) begin
							sx += dx; sy += dy; found = 1; moved = 1;
						end
					end
		end
		if (!in_grid(gx, gy) || blocked_cells[gy*SIDE+gx]) return ST_GOAL_BAD;
		for (int i = 0; i < CELLS; i++) wave_seen[i] = 0;
		head = 0; tail = 0;
		wave_seen[gy*SIDE+gx] = 1;
		wave_dist[gy*SIDE+gx] = 0;
		wave_fifo[tail++] = gy*SIDE+gx;
		while (head < tail) begin
			cur = wave_fifo[head++];
			cx = cur % SIDE; cy = cur / SIDE;
			if (cx == sx && cy == sy) break;
			for (int i = 0; i < 4; i++) begin
				nx = cx + STEP_DX[i]; ny = cy + STEP_DY[i];
				if (!passable(nx, ny)) continue;
				n = ny*SIDE + nx;
				if (wave_seen[n]) continue;
				wave_seen[n] = 1;
				wave_dist[n] = wave_dist[cur] + 1;
				if (tail < CELLS) wave_fifo[tail++] = n;
			end
		end
		if (!in_grid(sx, sy) || !wave_seen[sy*SIDE+sx]) return ST_NO_PATH;
		len = 0; cx = sx; cy = sy;
		trace[len++] = cy*SIDE + cx;
		guard = act_w * act_h;
		while (!(cx == gx && cy == gy) && guard > 0) begin
			guard--;
			bx = cx; by = cy; bd = wave_dist[cy*SIDE+cx];
			for (int i = 0; i < 4; i++) begin
				nx = cx + STEP_DX[i]; ny = cy + STEP_DY[i];
				if (!in_grid(nx, ny)) continue;
				n = ny*SIDE + nx;
				if (wave_seen[n] && wave_dist[n] < bd) begin
					bd = wave_dist[n]; bx = nx; by = ny;
				end
			end
			if (bx == cx && by == cy) break;
			cx = bx; cy = by;
			if (len < CELLS) trace[len++] = cy*SIDE + cx;
		end
		cnt = 0;
		if (len <= 2) begin
			for (int i = 0; i < len; i++) waypoints[cnt++] = trace[i];
		end else begin
			waypoints[cnt++] = trace[0];
			pdx = trace[1] % SIDE - trace[0] % SIDE;
			pdy = trace[1] / SIDE - trace[0] / SIDE;
			seg = 1;
			for (int i = 1; i + 1 < len; i++) begin
				ddx = trace[i+1] % SIDE - trace[i] % SIDE;
				ddy = trace[i+1] / SIDE - trace[i] / SIDE;
				if ((ddx != pdx || ddy != pdy) && seg >= cfg_seg) begin
					waypoints[cnt++] = trace[i];
					seg = 0;
				end
				pdx = ddx; pdy = ddy; seg++;
			end
			waypoints[cnt++] = trace[len-1];
		end
		waypoint_total = cnt;
		return ST_OK;
	endfunction

	function automatic result_t planner_result(request_t q);
		result_t r;
		bit mv;
		act_w = clamp_dim(cfg_w);
		act_h = clamp_dim(cfg_h);
		r.st = ST_OK; r.wx = 0; r.wy = 0; r.moved = 0;
		case (q.fn)
			FN_LOAD: occ_cells[q.cy*SIDE+q.cx] = {q.unk, q.occ};
			FN_PLAN: begin
				r.st = plan_path(int'(q.sx), int'(q.sy), int'(q.gx), int'(q.gy), mv);
				r.moved = mv;
			end
			FN_READ: begin
				if (q.idx >= waypoint_total) r.st = ST_BAD_INDEX;
				else begin
					r.wx = 6'(waypoints[q.idx] % SIDE);
					r.wy = 6'(waypoints[q.idx] / SIDE);
				end
			end
			default: ;
		endcase
		r.count = 13'(waypoint_total);
		return r;
	endfunction

	// sender: enters and leaves at a falling edge
	task automatic send_req(request_t q);
		while (!calm && $urandom_range(99) < 30) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		func = q.fn; cell_x = q.cx; cell_y = q.cy;
		cell_occupied = q.occ; cell_unknown = q.unk;
		start_x = q.sx; start_y = q.sy; goal_x = q.gx; goal_y = q.gy;
		waypoint_index = q.idx;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		expected_results.insert(expected_results.size(), planner_result(q));
		@(negedge clk);
	endtask

	task automatic write_reg(logic [2:0] addr, int value);
		in_valid = 1'b0;
		while (expected_results.size() != 0) @(negedge clk);
		repeat (8) @(negedge clk);
		cfg_en = 1'b1; cfg_addr = addr; cfg_wdata = value[6:0];
		@(negedge clk);
		cfg_en = 1'b0;
		case (addr)
			REG_GRID_WIDTH:  cfg_w = value & 127;
			REG_GRID_HEIGHT: cfg_h = value & 127;
			REG_ALLOW_UNK:   cfg_unk = value & 1;
			REG_INFLATION:   cfg_infl = value & 7;
			default:         cfg_seg = value & 127;
		endcase
	endtask

	task automatic set_grid(int w, int h, int au, int infl, int ms);
		write_reg(REG_GRID_WIDTH, w);
		write_reg(REG_GRID_HEIGHT, h);
		write_reg(REG_ALLOW_UNK, au);
		write_reg(REG_INFLATION, infl);
		write_reg(REG_MIN_SEGMENT, ms);
	endtask

	function automatic request_t mk(func_t fn, int a = 0, int b = 0, int c = 0, int d = 0,
			int idx = 0);
		request_t q;
		q = '{fn: fn, cx: 0, cy: 0, occ: 0, unk: 0, sx: 0, sy: 0, gx: 0, gy: 0,
			idx: 12'(idx)};
		if (fn == FN_LOAD) begin
			q.cx = 6'(a); q.cy = 6'(b); q.occ = 1'(c); q.unk = 1'(d);
		end else begin
			q.sx = 6'(a); q.sy = 6'(b); q.gx = 6'(c); q.gy = 6'(d);
		end
		return q;
	endfunction

	function automatic request_t random_req(int plan_pct);
		request_t q;
		int pick, aw, ah;
		aw = clamp_dim(cfg_w); ah = clamp_dim(cfg_h);
		q.cx = 6'($urandom); q.cy = 6'($urandom); q.sx = 6'($urandom); q.sy = 6'($urandom);
		q.gx = 6'($urandom); q.gy = 6'($urandom); q.idx = 12'($urandom);
		q.occ = $urandom_range(99) < 8;
		q.unk = $urandom_range(99) < 12;
		pick = $urandom_range(99);
		if (pick < plan_pct) q.fn = FN_PLAN;
		else if (pick < 60) q.fn = FN_LOAD;
		else if (pick < 95) q.fn = FN_READ;
		else q.fn = FN_NOP;
		if ($urandom_range(99) < 85) begin
			q.cx = 6'($urandom_range(aw-1)); q.cy = 6'($urandom_range(ah-1));
		end
		if ($urandom_range(99) < 90) begin
			q.sx = 6'($urandom_range(aw-1)); q.sy = 6'($urandom_range(ah-1));
			q.gx = 6'($urandom_range(aw-1)); q.gy = 6'($urandom_range(ah-1));
		end
		if ($urandom_range(99) < 80) q.idx = 12'($urandom_range(waypoint_total + 1));
		return q;
	endfunction

	task automatic test_directed_defaults();
		send_req(mk(FN_NOP));
		send_req(mk(FN_READ, 0, 0, 0, 0, 0));
		send_req(mk(FN_READ, 0, 0, 0, 0, 4095));
		send_req(mk(FN_LOAD, 63, 63, 1, 1));
		send_req(mk(FN_LOAD, 10, 10, 0, 1));
		send_req(mk(FN_LOAD, 0, 0, 0, 0));
		send_req(mk(FN_PLAN, 0, 0, 0, 0));
		send_req(mk(FN_READ, 0, 0, 0, 0, 0));
		send_req(mk(FN_PLAN, 0, 0, 20, 5));
		send_req(mk(FN_READ, 0, 0, 0, 0, 1));
		send_req(mk(FN_PLAN, 63, 62, 62, 62));
		send_req(mk(FN_PLAN, 63, 62, 40, 40));
		send_req(mk(FN_PLAN, 12, 10, 10, 10));
		send_req(mk(FN_PLAN, 10, 10, 30, 10));
	endtask

	task automatic test_single_row();
		set_grid(8, 1, 0, 0, 1);
		send_req(mk(FN_LOAD, 4, 0, 1, 0));
		send_req(mk(FN_PLAN, 0, 0, 7, 0));
		send_req(mk(FN_PLAN, 0, 0, 10, 0));
		send_req(mk(FN_PLAN, 10, 0, 6, 0));
		send_req(mk(FN_PLAN, 40, 0, 6, 0));
		send_req(mk(FN_READ, 0, 0, 0, 0, 1));
		send_req(mk(FN_LOAD, 4, 0, 0, 0));
		send_req(mk(FN_PLAN, 0, 0, 7, 0));
		send_req(mk(FN_READ, 0, 0, 0, 0, 1));
	endtask

	task automatic test_random_phase(int w, int h, int au, int infl, int ms, int items);
		int pct;
		set_grid(w, h, au, infl, ms);
		pct = (clamp_dim(w) * clamp_dim(h) > 1024) ? 2 : 12;
		for (int i = 0; i < items; i++) begin
			calm = (i >= items/3 && i < items/2);
			send_req(random_req(pct));
		end
		calm = 0;
	endtask

	task automatic test_output_backpressure();
		hold_off = 400;
		calm = 1;
		for (int i = 0; i < 20; i++) send_req(random_req(0));
		calm = 0;
	endtask

	// result side: random stalls and one long hold-off
	always @(negedge clk) begin
		if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			out_ready <= 1'b0;
		end else
			out_ready <= calm || $urandom_range(99) >= 30;
	end

	always @(posedge clk) begin : check_results
		result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result transaction: status %0d", status);
			end else begin
				want = expected_results.pop_front();
				if (status !== want.st || waypoint_count !== want.count ||
						waypoint_x !== want.wx || waypoint_y !== want.wy ||
						start_moved !== want.moved) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch exp %0d %0d (%0d,%0d) %0d got %0d %0d (%0d,%0d) %0d",
							want.st, want.count, want.wx, want.wy, want.moved,
							status, waypoint_count, waypoint_x, waypoint_y, start_moved);
				end
			end
		end
	end

	always @(posedge clk) begin : watchdog
		int quiet;
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
				(finished_sending && expected_results.size() == 0))
			quiet = 0;
		else begin
			quiet++;
			if (quiet >= IDLE_LIMIT) begin
				$display("grid_wavefront_path_planner verification failed");
				$finish;
			end
		end
	end

	initial begin
		waypoint_total = 0;
		mismatches = 0;
		calm = 0;
		hold_off = 0;
		finished_sending = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_directed_defaults();
		test_single_row();
		test_random_phase(64, 64, 0, 2, 5, 120);
		test_random_phase(8, 8, 1, 0, 1, 200);
		test_random_phase(0, 127, 0, 7, 127, 100);
		test_random_phase(16, 12, 1, 1, 0, 200);
		test_output_backpressure();
		test_random_phase(127, 0, 1, 3, 64, 100);
		test_random_phase(12, 16, 0, 1, 2, 200);
		test_random_phase(1, 1, 1, 0, 1, 60);
		test_random_phase(10, 10, 0, 0, 3, 200);
		test_random_phase(64, 64, 1, 7, 1, 60);
		test_random_phase(20, 6, 1, 1, 4, 150);
		in_valid = 1'b0;
		finished_sending = 1;
		while (expected_results.size() != 0) @(negedge clk);
		repeat (50) @(posedge clk);
		if (mismatches == 0 && expected_results.size() == 0)
			$display("grid_wavefront_path_planner verification clean");
		else
			$display("grid_wavefront_path_planner verification failed");
		$finish;
	end

endmodule
